### rtl/core/fpr_pkg.sv
// Package: shared constants and types for the FIFO page replacement block.
`default_nettype none

package fpr_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned FrameDepthDef = 16;
  localparam int unsigned PageBitsDef   = 16;

  // Fixed field widths of the stream and configuration ports
  localparam int unsigned CfgW      = 5;
  localparam int unsigned PageInW   = 16;
  localparam int unsigned IndexOutW = 4;
  localparam int unsigned EvictOutW = 16;
  localparam int unsigned TotalW    = 16;
  localparam int unsigned TdataOutW = 40;
  localparam int unsigned TuserOutW = 2;

  localparam logic [CfgW-1:0]   CfgReset = CfgW'(3);
  localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the reference and its match vector
    logic commit;   // update the frames and load the result register
  } cmd_t;

  // One result item
  typedef struct packed {
    logic                 hit;
    logic [IndexOutW-1:0] frame_index;
    logic                 evicted_valid;
    logic [EvictOutW-1:0] evicted_page;
    logic [TotalW-1:0]    fault_total;
    logic                 total_final;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/fifo_page_replacement_top.sv
// FIFO page replacement block: usage notes and top-level wiring.
// Input stream: one page reference per transfer; tdata carries page_number,
// tlast marks the final reference of a sequence.
// Output stream: one result per reference; tdata carries frame_index,
// evicted_page and fault_total, tuser carries hit and evicted_valid, tlast
// marks that fault_total is the final count of the sequence.
// Configuration: cfg_wr_en_i writes frames_in_use (clamped to 1..FRAME_DEPTH);
// write only while no reference is in flight.
// Timing: a reference is compared against all frames in its accept cycle and
// the match vector is registered; the frame store is updated and the result
// registered in the update step, which waits while the output register is full.
// A new reference is accepted only after the previous one has been committed,
// as set by the compare-then-update sequence over the frame store.
// A finished result waits in the output register while the next reference
// is accepted; if the sink stalls, the following reference holds in the
// update step until the register frees up.
// Reset clears all frames, counters and the pointer and sets frames_in_use
// to 3; a reference marked last clears the same state after its result.
`default_nettype none

module fifo_page_replacement_top #(
  parameter int unsigned FRAME_DEPTH = fpr_pkg::FrameDepthDef,
  parameter int unsigned PAGE_BITS   = fpr_pkg::PageBitsDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_wr_en_i,
  input  wire logic [fpr_pkg::CfgW-1:0]          cfg_wr_data_i,  // frames_in_use
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  input  wire logic [fpr_pkg::PageInW-1:0]       s_axis_tdata_i, // page_number
  input  wire logic                              s_axis_tlast_i,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // frame_index[3:0], evicted_page[19:4], fault_total[35:20], zero pad[39:36]
  output logic [fpr_pkg::TdataOutW-1:0]          m_axis_tdata_o,
  // hit[0], evicted_valid[1]
  output logic [fpr_pkg::TuserOutW-1:0]          m_axis_tuser_o,
  output logic                                   m_axis_tlast_o
);

  localparam int unsigned PadW = fpr_pkg::TdataOutW - fpr_pkg::IndexOutW
                                 - fpr_pkg::EvictOutW - fpr_pkg::TotalW;

  fpr_pkg::cmd_t    cmd;
  fpr_pkg::result_t result;

  fpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  fpr_datapath #(
    .FRAME_DEPTH (FRAME_DEPTH),
    .PAGE_BITS   (PAGE_BITS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_wr_en_i        (cfg_wr_en_i),
    .cfg_wr_data_i      (cfg_wr_data_i),
    .page_number_i      (s_axis_tdata_i),
    .last_in_sequence_i (s_axis_tlast_i),
    .cmd_i              (cmd),
    .result_o           (result)
  );

  assign m_axis_tdata_o = {{PadW{1'b0}}, result.fault_total, result.evicted_page,
                           result.frame_index};
  assign m_axis_tuser_o = {result.evicted_valid, result.hit};
  assign m_axis_tlast_o = result.total_final;

  // one reference at a time: no accept in the cycle after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("reference accepted during update step");

  // a hit never evicts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> !m_axis_tuser_o[1])
    else $error("eviction reported on a hit");

  // without an eviction the evicted page reads zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[1]) |-> (m_axis_tdata_o[19:4] == '0))
    else $error("evicted page nonzero without eviction");

endmodule

`default_nettype wire

### rtl/core/fpr_ctrl.sv
// Controller: sequences lookup and commit, owns the result valid flag.
`default_nettype none

module fpr_ctrl (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output fpr_pkg::cmd_t    cmd_o
);

  typedef enum logic {
    StIdle,
    StUpdate
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   out_valid_q;
  logic   out_valid_d;
  logic   capture;
  logic   commit;

  assign in_ready_o = (state_q == StIdle);
  assign capture    = in_valid_i && in_ready_o;
  // result register is free when empty or being drained this cycle
  assign commit     = (state_q == StUpdate) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (capture) begin
          state_d = StUpdate;
        end
      end
      StUpdate: begin
        if (commit) begin
          state_d     = StIdle;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cmd_o.capture = capture;
  assign cmd_o.commit  = commit;

endmodule

`default_nettype wire

### rtl/core/fpr_datapath.sv
// Datapath: frame store, parallel compare, fill/evict update and result register.
`default_nettype none

module fpr_datapath #(
  parameter int unsigned FRAME_DEPTH = fpr_pkg::FrameDepthDef,
  parameter int unsigned PAGE_BITS   = fpr_pkg::PageBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_wr_en_i,
  input  wire logic [fpr_pkg::CfgW-1:0]      cfg_wr_data_i,
  input  wire logic [fpr_pkg::PageInW-1:0]   page_number_i,
  input  wire logic                          last_in_sequence_i,
  input  wire fpr_pkg::cmd_t                 cmd_i,
  output fpr_pkg::result_t                   result_o
);

  localparam int unsigned CntW = $clog2(FRAME_DEPTH + 1);
  localparam int unsigned IdxW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;

  logic [fpr_pkg::CfgW-1:0]   cfg_q;
  logic [PAGE_BITS-1:0]       pages_q [FRAME_DEPTH];
  logic [FRAME_DEPTH-1:0]     valid_q;
  logic [FRAME_DEPTH-1:0]     valid_d;
  logic [CntW-1:0]            fill_q;
  logic [CntW-1:0]            fill_d;
  logic [IdxW-1:0]            ptr_q;
  logic [IdxW-1:0]            ptr_d;
  logic [fpr_pkg::TotalW-1:0] fault_q;
  logic [fpr_pkg::TotalW-1:0] fault_d;
  logic [PAGE_BITS-1:0]       page_q;
  logic                       last_q;
  logic [FRAME_DEPTH-1:0]     match_q;
  logic [FRAME_DEPTH-1:0]     match_d;
  fpr_pkg::result_t           result_q;
  fpr_pkg::result_t           result_d;

  logic [CntW-1:0]            cap;
  logic [PAGE_BITS-1:0]       page_in;
  logic                       found;
  logic [IdxW-1:0]            hit_idx;
  logic [IdxW-1:0]            victim;
  logic [CntW-1:0]            victim_next;
  logic [IdxW-1:0]            where;
  logic                       ev_valid;
  logic [PAGE_BITS-1:0]       ev_page;
  logic                       do_write;

  // capacity clamped to 1..FRAME_DEPTH
  always_comb begin
    if (cfg_q == '0) begin
      cap = CntW'(1);
    end else if (32'(cfg_q) > FRAME_DEPTH) begin
      cap = CntW'(FRAME_DEPTH);
    end else begin
      cap = CntW'(cfg_q);
    end
  end

  assign page_in = PAGE_BITS'(page_number_i);

  // one comparator per frame, masked by valid and capacity
  always_comb begin
    for (int i = 0; i < FRAME_DEPTH; i++) begin
      match_d[i] = valid_q[i] && (CntW'(i) < cap) && (pages_q[i] == page_in);
    end
  end

  // lowest matching frame wins
  always_comb begin
    hit_idx = '0;
    for (int i = FRAME_DEPTH - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        hit_idx = IdxW'(i);
      end
    end
  end

  assign found = |match_q;

  always_comb begin
    victim      = (CntW'(ptr_q) >= cap) ? '0 : ptr_q;
    victim_next = CntW'(victim) + CntW'(1);
    if (victim_next >= cap) begin
      victim_next = '0;
    end
  end

  always_comb begin
    valid_d  = valid_q;
    fill_d   = fill_q;
    ptr_d    = ptr_q;
    fault_d  = fault_q;
    where    = hit_idx;
    ev_valid = 1'b0;
    ev_page  = '0;
    do_write = 1'b0;
    if (!found) begin
      do_write = 1'b1;
      if (fill_q < cap) begin
        where  = fill_q[IdxW-1:0];
        fill_d = fill_q + CntW'(1);
      end else begin
        where    = victim;
        ev_valid = valid_q[victim];
        ev_page  = valid_q[victim] ? pages_q[victim] : '0;
        ptr_d    = victim_next[IdxW-1:0];
      end
      valid_d[where] = 1'b1;
      if (fault_q != fpr_pkg::TotalMax) begin
        fault_d = fault_q + fpr_pkg::TotalW'(1);
      end
    end

    result_d.hit           = found;
    result_d.frame_index   = fpr_pkg::IndexOutW'(where);
    result_d.evicted_valid = ev_valid;
    result_d.evicted_page  = fpr_pkg::EvictOutW'(ev_page);
    result_d.fault_total   = fault_d;
    result_d.total_final   = last_q;

    // end of sequence: start afresh after reporting
    if (last_q) begin
      valid_d = '0;
      fill_d  = '0;
      ptr_d   = '0;
      fault_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q   <= fpr_pkg::CfgReset;
      valid_q <= '0;
      fill_q  <= '0;
      ptr_q   <= '0;
      fault_q <= '0;
    end else begin
      if (cfg_wr_en_i) begin
        cfg_q <= cfg_wr_data_i;
      end
      if (cmd_i.commit) begin
        valid_q <= valid_d;
        fill_q  <= fill_d;
        ptr_q   <= ptr_d;
        fault_q <= fault_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      page_q  <= page_in;
      last_q  <= last_in_sequence_i;
      match_q <= match_d;
    end
    if (cmd_i.commit) begin
      result_q <= result_d;
      if (do_write) begin
        pages_q[where] <= page_q;
      end
    end
  end

  assign result_o = result_q;

endmodule

`default_nettype wire
